[sv/lncc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lncc_pkg
// Shared types for the local ncc voxel term: payloads, controller states,
// datapath commands and status.
// ----------------------------------------------------------------------------
package lncc_pkg;

  localparam int unsigned SUM_W = 57;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned KV_W  = 12;

  typedef struct packed {
    logic signed [31:0] pred_mean;
    logic signed [31:0] target_mean;
    logic signed [31:0] pred_sq_mean;
    logic signed [31:0] target_sq_mean;
    logic signed [31:0] cross_mean;
    logic               last_voxel;
  } in_item_t;

  typedef struct packed {
    logic [24:0]      ncc_value;
    logic [SUM_W-1:0] ncc_total;
    logic [CNT_W-1:0] voxel_count;
    logic             volume_done;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_DIFF,
    ST_SCALE,
    ST_FLOOR,
    ST_MUL,
    ST_CMP,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PROD,
    OP_DIFF,
    OP_SCALE,
    OP_FLOOR,
    OP_MUL,
    OP_CMP,
    OP_DIV,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] mul_step;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

[sv/lncc_stream_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lncc_stream_if
// Valid/ready channel carrying one item of type T.
// ----------------------------------------------------------------------------
interface lncc_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[sv/local_ncc_voxel_term.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// local_ncc_voxel_term
// Local normalized cross-correlation term per voxel with running sum/count.
// ----------------------------------------------------------------------------
// One voxel item is processed at a time, in these steps after acceptance: the
// mean products, differences, kv scaling and variance floor, four passes of a
// 32x32 partial-product multiplier for cross^2 and pvar*tvar, one compare, a
// restoring divider producing one quotient bit per cycle for FRAC_BITS bits,
// a finish step that waits for the output register, and the idle state that
// takes the next item.
// The result sits in an output register, so a new item is accepted while it
// waits; the block only stalls at the end of the next item if the result is
// still held. ncc_total and voxel_count saturate and clear after an item with
// last_voxel. kernel_volume is written over the APB port at byte address 0;
// the user writes it only while idle, and the block itself does not enforce it.
module local_ncc_voxel_term #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  lncc_stream_if.sink               voxel_in,
  lncc_stream_if.source             term_out,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  logic [lncc_pkg::KV_W-1:0] kernel_volume;
  lncc_pkg::cmd_t            cmd;
  lncc_pkg::status_t         status;
  lncc_pkg::in_item_t        in_item;
  lncc_pkg::out_item_t       out_item;

  assign pready = 1'b1;
  // register index is paddr[2]; only index zero exists
  assign prdata = paddr[2] ? 32'd0 : 32'(kernel_volume);

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_volume <= lncc_pkg::KV_W'(1);
    end else if (psel && penable && pwrite && !paddr[2]) begin
      kernel_volume <= pwdata[lncc_pkg::KV_W-1:0];
    end
  end

  assign in_item          = voxel_in.payload;
  assign term_out.payload = out_item;

  lncc_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (voxel_in.valid),
    .in_ready (voxel_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  lncc_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_item   (in_item),
    .kv        (kernel_volume),
    .out_valid (term_out.valid),
    .out_ready (term_out.ready),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

[sv/lncc_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lncc_ctrl
// Sequencer for one voxel: products, scaling, wide multiply, division, finish.
// ----------------------------------------------------------------------------
module lncc_ctrl #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire lncc_pkg::status_t status,
  output lncc_pkg::cmd_t        cmd
);

  localparam logic [4:0] DIV_LAST = 5'(FRAC_BITS - 1);

  lncc_pkg::state_t state, state_next;
  logic [4:0]       cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lncc_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    in_ready     = 1'b0;
    cmd.op       = lncc_pkg::OP_NONE;
    cmd.mul_step = cnt[1:0];
    unique case (state)
      lncc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = lncc_pkg::OP_LOAD;
          state_next = lncc_pkg::ST_PROD;
        end
      end
      lncc_pkg::ST_PROD: begin
        cmd.op     = lncc_pkg::OP_PROD;
        state_next = lncc_pkg::ST_DIFF;
      end
      lncc_pkg::ST_DIFF: begin
        cmd.op     = lncc_pkg::OP_DIFF;
        state_next = lncc_pkg::ST_SCALE;
      end
      lncc_pkg::ST_SCALE: begin
        cmd.op     = lncc_pkg::OP_SCALE;
        state_next = lncc_pkg::ST_FLOOR;
      end
      lncc_pkg::ST_FLOOR: begin
        cmd.op     = lncc_pkg::OP_FLOOR;
        cnt_next   = '0;
        state_next = lncc_pkg::ST_MUL;
      end
      lncc_pkg::ST_MUL: begin
        cmd.op   = lncc_pkg::OP_MUL;
        cnt_next = cnt + 5'd1;
        if (cnt[1:0] == 2'd3) begin
          state_next = lncc_pkg::ST_CMP;
        end
      end
      lncc_pkg::ST_CMP: begin
        cmd.op     = lncc_pkg::OP_CMP;
        cnt_next   = '0;
        state_next = lncc_pkg::ST_DIV;
      end
      lncc_pkg::ST_DIV: begin
        cmd.op   = lncc_pkg::OP_DIV;
        cnt_next = cnt + 5'd1;
        if (cnt == DIV_LAST) begin
          state_next = lncc_pkg::ST_FINISH;
        end
      end
      lncc_pkg::ST_FINISH: begin
        // hold until the output register can take the result
        if (status.out_free) begin
          cmd.op     = lncc_pkg::OP_FINISH;
          state_next = lncc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lncc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[sv/lncc_dpath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lncc_dpath
// Datapath: mean products, kv scaling, variance floor, split wide multiply,
// restoring divider, accumulators and output register.
// ----------------------------------------------------------------------------
module lncc_dpath #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire lncc_pkg::cmd_t                cmd,
  output lncc_pkg::status_t                  status,
  input  wire lncc_pkg::in_item_t            in_item,
  input  wire logic [lncc_pkg::KV_W-1:0]     kv,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output lncc_pkg::out_item_t                out_item
);

  localparam int unsigned DW = 65 - FRAC_BITS;
  localparam int unsigned SW = DW + 13;
  localparam int unsigned UW = SW - 1;
  localparam int unsigned AW = 2 * UW + 2;
  localparam longint unsigned EPS_Q =
    ((64'd1 << FRAC_BITS) + 64'd50000) / 64'd100000;
  localparam longint unsigned EPS_Q2 =
    ((64'd1 << (2 * FRAC_BITS)) + 64'd50000) / 64'd100000;
  localparam logic signed [SW-1:0] EPS_S = SW'(EPS_Q);
  localparam int unsigned SUM_W = lncc_pkg::SUM_W;
  localparam int unsigned CNT_W = lncc_pkg::CNT_W;

  logic signed [31:0]    pm, tm, psq, tsq, cm;
  logic                  last;
  logic signed [63:0]    prod_c, prod_p, prod_t;
  logic signed [DW-1:0]  diff_c, diff_p, diff_t;
  logic signed [SW-1:0]  sc_c, sc_p, sc_t;
  logic [UW-1:0]         a_c, v_p, v_t;
  logic [AW-1:0]         num, den, rem;
  logic [FRAC_BITS-1:0]  quo;
  logic                  sat;
  logic [SUM_W-1:0]      sum_acc;
  logic [CNT_W-1:0]      cnt_acc;

  logic signed [12:0]    kvs;
  logic [63:0]           ac64, vp64, vt64;
  logic [31:0]           xa, xb, ya, yb;
  logic [63:0]           pp_n, pp_d;
  logic [6:0]            sh;
  logic [AW:0]           rem2;
  logic [30:0]           ncc;
  logic [SUM_W:0]        sum_ext;
  logic [SUM_W-1:0]      sum_new;
  logic [CNT_W-1:0]      cnt_new;

  assign kvs  = $signed({1'b0, kv});
  assign ac64 = 64'(a_c);
  assign vp64 = 64'(v_p);
  assign vt64 = 64'(v_t);
  // partial product: step bit 0 picks the first operand half, bit 1 the second
  assign xa   = cmd.mul_step[0] ? ac64[63:32] : ac64[31:0];
  assign xb   = cmd.mul_step[1] ? ac64[63:32] : ac64[31:0];
  assign ya   = cmd.mul_step[0] ? vp64[63:32] : vp64[31:0];
  assign yb   = cmd.mul_step[1] ? vt64[63:32] : vt64[31:0];
  assign pp_n = 64'(xa) * 64'(xb);
  assign pp_d = 64'(ya) * 64'(yb);
  assign sh   = {(2'(cmd.mul_step[0]) + 2'(cmd.mul_step[1])), 5'd0};
  assign rem2 = {rem, 1'b0};

  assign ncc     = sat ? (31'd1 << FRAC_BITS) : 31'(quo);
  assign sum_ext = {1'b0, sum_acc} + (SUM_W + 1)'(ncc);
  assign sum_new = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
  assign cnt_new = (&cnt_acc) ? cnt_acc : cnt_acc + 1'b1;

  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      lncc_pkg::OP_LOAD: begin
        pm   <= in_item.pred_mean;
        tm   <= in_item.target_mean;
        psq  <= in_item.pred_sq_mean;
        tsq  <= in_item.target_sq_mean;
        cm   <= in_item.cross_mean;
        last <= in_item.last_voxel;
      end
      lncc_pkg::OP_PROD: begin
        prod_c <= 64'(pm) * 64'(tm);
        prod_p <= 64'(pm) * 64'(pm);
        prod_t <= 64'(tm) * 64'(tm);
      end
      lncc_pkg::OP_DIFF: begin
        // arithmetic shift is floor rounding
        diff_c <= DW'(cm) - DW'(prod_c >>> FRAC_BITS);
        diff_p <= DW'(psq) - DW'(prod_p >>> FRAC_BITS);
        diff_t <= DW'(tsq) - DW'(prod_t >>> FRAC_BITS);
      end
      lncc_pkg::OP_SCALE: begin
        sc_c <= SW'(kvs) * SW'(diff_c);
        sc_p <= SW'(kvs) * SW'(diff_p);
        sc_t <= SW'(kvs) * SW'(diff_t);
      end
      lncc_pkg::OP_FLOOR: begin
        a_c <= sc_c[SW-1] ? UW'(-sc_c) : UW'(sc_c);
        v_p <= (sc_p < EPS_S) ? UW'(EPS_S) : UW'(sc_p);
        v_t <= (sc_t < EPS_S) ? UW'(EPS_S) : UW'(sc_t);
        num <= AW'(EPS_Q2);
        den <= AW'(EPS_Q2);
      end
      lncc_pkg::OP_MUL: begin
        num <= num + (AW'(pp_n) << sh);
        den <= den + (AW'(pp_d) << sh);
      end
      lncc_pkg::OP_CMP: begin
        sat <= (num >= den);
        rem <= num;
        quo <= '0;
      end
      lncc_pkg::OP_DIV: begin
        if (rem2 >= (AW + 1)'(den)) begin
          rem <= AW'(rem2 - (AW + 1)'(den));
          quo <= {quo[FRAC_BITS-2:0], 1'b1};
        end else begin
          rem <= AW'(rem2);
          quo <= {quo[FRAC_BITS-2:0], 1'b0};
        end
      end
      lncc_pkg::OP_FINISH: begin
        out_item.ncc_value   <= ncc[24:0];
        out_item.ncc_total   <= sum_new;
        out_item.voxel_count <= cnt_new;
        out_item.volume_done <= last;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sum_acc   <= '0;
      cnt_acc   <= '0;
    end else begin
      if (cmd.op == lncc_pkg::OP_FINISH) begin
        out_valid <= 1'b1;
        sum_acc   <= last ? '0 : sum_new;
        cnt_acc   <= last ? '0 : cnt_new;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[sv/lncc_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lncc_checker
// Port-level checks on the voxel term block, bound to the top level.
// ----------------------------------------------------------------------------
module lncc_checker #(
  parameter int unsigned FRAC_BITS = 24
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire lncc_pkg::out_item_t   out_item
);

  logic after_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      after_done <= 1'b0;
    end else if (out_valid && out_ready) begin
      after_done <= out_item.volume_done;
    end
  end

  a_ncc_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (FRAC_BITS > 24) || (out_item.ncc_value <= (25'd1 << FRAC_BITS)))
    else $error("ncc term above one");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.voxel_count != '0)
    else $error("result with zero voxel count");

  a_volume_restart: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && after_done) |->
      (out_item.voxel_count == 32'd1 && out_item.ncc_total == 57'(out_item.ncc_value)))
    else $error("accumulators not cleared after volume end");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
    else $error("result dropped or changed while stalled");

endmodule

bind local_ncc_voxel_term lncc_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_lncc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (term_out.valid),
  .out_ready (term_out.ready),
  .out_item  (term_out.payload)
);
`default_nettype wire

[verif/tb_local_ncc_voxel_term.sv]
// ----------------------------------------------------------------------------
// tb_local_ncc_voxel_term
// Drives random and edge-case voxel items through the local ncc term block,
// recomputes each ncc term, running sum and count, and compares every result
// item field by field. kernel_volume is rewritten between phases while idle.
// ----------------------------------------------------------------------------
module tb_local_ncc_voxel_term;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FB = 24;
  localparam longint unsigned EPS_LIN = ((64'd1 << FB) + 64'd50000) / 64'd100000;
  localparam longint unsigned EPS_SQ = ((64'd1 << (2 * FB)) + 64'd50000) / 64'd100000;
  localparam logic [56:0] SUM_SAT = {57{1'b1}};
  localparam logic [2:0] ADDR_KV = 3'd0;
  localparam int unsigned STALL_LIMIT = 20000;

  // ncc term predictor and queue of pending results
  class ncc_scoreboard;
    logic [11:0] kv;
    logic [56:0] sum_acc;
    logic [31:0] cnt_acc;
    lncc_pkg::out_item_t pending[$];
    int errors;

    function new();
      kv = 12'd1;
      sum_acc = '0;
      cnt_acc = '0;
      errors = 0;
    endfunction

    function automatic longint signed floor_prod(longint signed a, longint signed b);
      return (a * b) >>> FB;
    endfunction

    function automatic longint signed var_floor(longint signed m, longint signed sq);
      longint signed v;
      v = longint'(kv) * (sq - floor_prod(m, m));
      if (v < longint'(EPS_LIN)) v = longint'(EPS_LIN);
      return v;
    endfunction

    function void note_voxel(lncc_pkg::in_item_t it);
      longint signed pm, tm, cr, pv, tv;
      logic [127:0] num, den;
      logic [63:0] ac;
      logic [24:0] term;
      lncc_pkg::out_item_t r;
      pm = it.pred_mean;
      tm = it.target_mean;
      cr = longint'(kv) * (longint'(it.cross_mean) - floor_prod(pm, tm));
      pv = var_floor(pm, it.pred_sq_mean);
      tv = var_floor(tm, it.target_sq_mean);
      ac = cr < 0 ? 64'(-cr) : 64'(cr);
      num = 128'(ac) * 128'(ac) + 128'(EPS_SQ);
      den = 128'(64'(pv)) * 128'(64'(tv)) + 128'(EPS_SQ);
      if (num >= den) term = 25'(1) << FB;
      else term = 25'((num << FB) / den);
      if (sum_acc > SUM_SAT - 57'(term)) sum_acc = SUM_SAT;
      else sum_acc = sum_acc + 57'(term);
      if (cnt_acc != 32'hFFFF_FFFF) cnt_acc = cnt_acc + 1;
      r.ncc_value = term;
      r.ncc_total = sum_acc;
      r.voxel_count = cnt_acc;
      r.volume_done = it.last_voxel;
      pending.push_back(r);
      if (it.last_voxel) begin
        sum_acc = '0;
        cnt_acc = '0;
      end
    endfunction

    function void check_term(lncc_pkg::out_item_t got);
      lncc_pkg::out_item_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.ncc_value !== exp_r.ncc_value) begin
        $display("%0t: ncc_value exp %h got %h", $realtime, exp_r.ncc_value, got.ncc_value);
        errors++;
      end
      if (got.ncc_total !== exp_r.ncc_total) begin
        $display("%0t: ncc_total exp %h got %h", $realtime, exp_r.ncc_total, got.ncc_total);
        errors++;
      end
      if (got.voxel_count !== exp_r.voxel_count) begin
        $display("%0t: voxel_count exp %h got %h", $realtime, exp_r.voxel_count,
                 got.voxel_count);
        errors++;
      end
      if (got.volume_done !== exp_r.volume_done) begin
        $display("%0t: volume_done exp %b got %b", $realtime, exp_r.volume_done,
                 got.volume_done);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int unsigned idle_cycles = 0;

  lncc_stream_if #(.T(lncc_pkg::in_item_t)) voxel_in ();
  lncc_stream_if #(.T(lncc_pkg::out_item_t)) term_out ();

  local_ncc_voxel_term #(.FRAC_BITS(FB)) DUT (
    .clk(clk), .rst(rst), .voxel_in(voxel_in.sink), .term_out(term_out.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ncc_scoreboard sb = new();

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    voxel_in.valid = 1'b0;
    voxel_in.payload = '0;
    term_out.ready = 1'b0;
  end

  function automatic int gap_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(3, 1);
    return $urandom_range(80, 10);
  endfunction

  // sample results at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (term_out.valid && term_out.ready) sb.check_term(term_out.payload);
      if ((voxel_in.valid && voxel_in.ready) || (term_out.valid && term_out.ready))
        idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_local_ncc_voxel_term: FAIL");
        $finish;
      end
    end
  end

  // result ready toggles at random, with stall-free stretches
  initial begin
    int g;
    bit calm;
    calm = 0;
    @(negedge clk);
    forever begin
      if ($urandom_range(199) == 0) calm = !calm;
      g = calm ? 0 : gap_len();
      term_out.ready <= 1'b0;
      repeat (g) @(negedge clk);
      term_out.ready <= 1'b1;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
  end

  task automatic write_kv(logic [11:0] v);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= ADDR_KV; pwdata <= 32'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.kv = v;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic send_voxel(lncc_pkg::in_item_t it, int g);
    if (g > 0) begin
      voxel_in.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    voxel_in.valid <= 1'b1;
    voxel_in.payload <= it;
    do @(posedge clk); while (!voxel_in.ready);
    sb.note_voxel(it);
    @(negedge clk);
  endtask

  task automatic drain();
    voxel_in.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_mean();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(1 << 25))) - 32'(1 << 24);
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return 32'($urandom_range(1 << 24));
    endcase
  endfunction

  // mostly statistically consistent means so ncc falls below 1
  function automatic lncc_pkg::in_item_t rand_voxel(bit last);
    lncc_pkg::in_item_t it;
    longint signed p, t;
    it.pred_mean = rand_mean();
    it.target_mean = rand_mean();
    if ($urandom_range(3) != 0) begin
      p = it.pred_mean;
      t = it.target_mean;
      it.pred_sq_mean = 32'(((p * p) >>> FB) + $urandom_range(1 << 24));
      it.target_sq_mean = 32'(((t * t) >>> FB) + $urandom_range(1 << 24));
      it.cross_mean = 32'(((p * t) >>> FB) + $signed($urandom_range(1 << 24)) -
                          (1 << 23));
    end else begin
      it.pred_sq_mean = $urandom();
      it.target_sq_mean = $urandom();
      it.cross_mean = $urandom();
    end
    it.last_voxel = last;
    return it;
  endfunction

  initial begin
    lncc_pkg::in_item_t it;
    logic [31:0] ext[4];
    logic [11:0] kvs[6];
    int n;
    ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
    kvs = '{12'd1, 12'd3375, 12'd27, 12'd0, 12'd4095, 12'd125};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes, zero variance, saturated and fractional terms
    for (int i = 0; i < 4; i++) begin
      it.pred_mean = ext[i]; it.target_mean = ext[3 - i];
      it.pred_sq_mean = ext[(i + 1) % 4]; it.target_sq_mean = ext[(i + 2) % 4];
      it.cross_mean = ext[i]; it.last_voxel = i[0];
      send_voxel(it, 0);
    end
    it = '0;
    send_voxel(it, 0);
    it.pred_sq_mean = 32'h0100_0000; it.target_sq_mean = 32'h0100_0000;
    it.cross_mean = 32'h0000_1000;
    send_voxel(it, 1);
    it.last_voxel = 1'b1;
    send_voxel(it, 0);
    drain();

    n = 0;
    for (int ph = 0; ph < 6; ph++) begin
      write_kv(kvs[ph]);
      for (int k = 0; k < 160; k++) begin
        send_voxel(rand_voxel($urandom_range(15) == 0), gap_len());
        n++;
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_local_ncc_voxel_term: PASS");
    end else begin
      $display("tb_local_ncc_voxel_term: FAIL");
    end
    $finish;
  end
endmodule
